/* hw/rtl/lic_pkg.sv */
// Shared types and codes for the LRU record cache directory.
// No dependencies; every module of the block imports this package.
package lic_pkg;

  localparam int IndexWidth = 16;
  localparam int SlotFieldWidth = 4;
  localparam int WbFieldWidth = 10;

  localparam logic KIND_ACCESS = 1'b0;
  localparam logic KIND_MARK = 1'b1;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_UNCACHED = 2'd2;

  typedef struct packed {
    logic kind;
    logic signed [IndexWidth-1:0] record_index;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic hit;
    logic [SlotFieldWidth-1:0] slot;
    logic writeback_needed;
    logic [WbFieldWidth-1:0] writeback_index;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic lookup;
    logic in_range;
    logic update;
    logic hit;
    logic mark;
  } cell_cmd_t;

endpackage

/* hw/rtl/lic_cell.sv */
// One recency position of the LRU chain: slot number, tag, dirty and valid.
// Depends on lic_pkg; the top level chains CACHE_SLOTS of these.
module lic_cell import lic_pkg::*; #(
  parameter int TAG_W = 10,
  parameter int SLOT_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  cell_cmd_t         cmd,
  input  logic [TAG_W-1:0]  req_tag,
  input  logic              prev_valid,
  input  logic [SLOT_W-1:0] prev_slot,
  input  logic [TAG_W-1:0]  prev_tag,
  input  logic              prev_dirty,
  input  logic              match_after,
  output logic              valid,
  output logic [SLOT_W-1:0] slot,
  output logic [TAG_W-1:0]  tag,
  output logic              dirty,
  output logic              match,
  output logic              match_from
);

  logic shift;

  // A hit anywhere at or behind this position means the entry moves back one place.
  assign match_from = match | match_after;
  assign shift = cmd.update & (cmd.hit ? match_from : prev_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (cmd.lookup) begin
        match <= valid & cmd.in_range & (tag == req_tag);
      end
      if (shift) begin
        valid <= prev_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      slot <= prev_slot;
      tag <= prev_tag;
      dirty <= prev_dirty;
    end else if (cmd.mark && match) begin
      dirty <= 1'b1;
    end
  end

endmodule

/* hw/rtl/lru_inode_cache_controller.sv */
// LRU record cache directory: each request has a lookup state, which compares the request
// tag in every cell of the recency chain, then an update state, which shifts the chain and
// registers the result; the next request can enter during an update that is not stalled. The
// shift runs through a chain of CACHE_SLOTS cells ordered most recent first, and the
// hit-position signal ripples along that chain. One result per request; a result may
// wait in the output register while the next request is already being looked up.
module lru_inode_cache_controller import lic_pkg::*; #(
  parameter int CACHE_SLOTS = 16,
  parameter int FILE_COUNT = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int TAG_W = $clog2(FILE_COUNT);
  localparam int SLOT_W = $clog2(CACHE_SLOTS);
  localparam int USED_W = $clog2(CACHE_SLOTS + 1);

  state_t state, state_next;

  logic             req_kind;
  logic [TAG_W-1:0] req_tag;
  logic             req_in_range;
  logic [USED_W-1:0] slots_used;

  logic              ch_valid [CACHE_SLOTS+1];
  logic [SLOT_W-1:0] ch_slot  [CACHE_SLOTS+1];
  logic [TAG_W-1:0]  ch_tag   [CACHE_SLOTS+1];
  logic              ch_dirty [CACHE_SLOTS+1];
  logic              mfrom    [CACHE_SLOTS+1];
  logic [CACHE_SLOTS-1:0] match_vec;

  cell_cmd_t cmd;
  logic advance, take_in, in_range_now, full, any_hit;
  logic [SLOT_W-1:0] hit_slot, miss_slot, res_slot;
  logic hit_dirty;
  logic [SLOT_W+SlotFieldWidth-1:0] slot_ext;
  logic [TAG_W+WbFieldWidth-1:0] wb_ext;
  out_t res;

  assign advance = !out_valid || !out_stall;
  assign in_stall = !(state == ST_IDLE || (state == ST_UPDATE && advance));
  assign take_in = in_valid && !in_stall;
  assign in_range_now = !in_data.record_index[IndexWidth-1] &&
      ({1'b0, in_data.record_index[IndexWidth-2:0]} < IndexWidth'(FILE_COUNT));
  assign full = slots_used == USED_W'(CACHE_SLOTS);
  assign any_hit = |match_vec;

  always_comb begin
    hit_slot = '0;
    hit_dirty = 1'b0;
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      hit_slot = hit_slot | (ch_slot[i+1] & {SLOT_W{match_vec[i]}});
      hit_dirty = hit_dirty | (ch_dirty[i+1] & match_vec[i]);
    end
  end

  // Victim is the last cell once full; otherwise the next unused slot.
  assign miss_slot = full ? ch_slot[CACHE_SLOTS] : slots_used[SLOT_W-1:0];
  assign res_slot = any_hit ? hit_slot : miss_slot;

  // Front of the chain: entry loaded into the most recent position.
  assign ch_valid[0] = 1'b1;
  assign ch_slot[0] = res_slot;
  assign ch_tag[0] = req_tag;
  assign ch_dirty[0] = any_hit ? hit_dirty : 1'b0;
  assign mfrom[CACHE_SLOTS] = 1'b0;

  always_comb begin
    cmd.lookup = state == ST_LOOKUP;
    cmd.in_range = req_in_range;
    cmd.update = state == ST_UPDATE && advance && req_kind == KIND_ACCESS && req_in_range;
    cmd.hit = any_hit;
    cmd.mark = state == ST_UPDATE && advance && req_kind == KIND_MARK;
  end

  for (genvar g = 0; g < CACHE_SLOTS; g++) begin : g_cell
    lic_cell #(
      .TAG_W (TAG_W),
      .SLOT_W(SLOT_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .req_tag    (req_tag),
      .prev_valid (ch_valid[g]),
      .prev_slot  (ch_slot[g]),
      .prev_tag   (ch_tag[g]),
      .prev_dirty (ch_dirty[g]),
      .match_after(mfrom[g+1]),
      .valid      (ch_valid[g+1]),
      .slot       (ch_slot[g+1]),
      .tag        (ch_tag[g+1]),
      .dirty      (ch_dirty[g+1]),
      .match      (match_vec[g]),
      .match_from (mfrom[g])
    );
  end

  always_comb begin
    slot_ext = (SLOT_W + SlotFieldWidth)'(res_slot);
    wb_ext = (TAG_W + WbFieldWidth)'(ch_tag[CACHE_SLOTS]);
    res = '0;
    if (req_kind == KIND_MARK) begin
      if (any_hit) begin
        res.status = STAT_DONE;
        res.hit = 1'b1;
        res.slot = slot_ext[SlotFieldWidth-1:0];
      end else begin
        res.status = STAT_UNCACHED;
      end
    end else if (!req_in_range) begin
      res.status = STAT_RANGE;
    end else begin
      res.status = STAT_DONE;
      res.hit = any_hit;
      res.slot = slot_ext[SlotFieldWidth-1:0];
      if (!any_hit && full && ch_dirty[CACHE_SLOTS]) begin
        res.writeback_needed = 1'b1;
        res.writeback_index = wb_ext[WbFieldWidth-1:0];
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take_in) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (advance) state_next = take_in ? ST_LOOKUP : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      slots_used <= '0;
    end else begin
      state <= state_next;
      if (state == ST_UPDATE && advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.update && !any_hit && !full) begin
        slots_used <= slots_used + USED_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      req_kind <= in_data.kind;
      req_tag <= in_data.record_index[TAG_W-1:0];
      req_in_range <= in_range_now;
    end
    if (state == ST_UPDATE && advance) begin
      out_data <= res;
    end
  end

endmodule

/* tb/sv/lru_inode_cache_controller_test.sv */
// Self-checking bench for the LRU record cache directory: a directed table, then random
// traffic over changing hot sets, each result checked against a behavioural directory.
// Depends on lic_pkg and lru_inode_cache_controller.
module lru_inode_cache_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lic_pkg::*;

  localparam int Slots = 16;
  localparam int Files = 1024;
  localparam int RunLimit = 400000;
  localparam int DrainCycles = 12;
  localparam int PhaseItems = 380;

  typedef struct packed {
    in_t  req;
    logic known;
    out_t want;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // behavioural copy of the directory
  logic [9:0] rec_tag [Slots];
  logic       rec_dirty [Slots];
  logic [3:0] lru_chain [Slots];
  int         slots_filled = 0;

  out_t pending_res[$];
  int   hot_set[$];

  int src_idle = 35;
  int snk_idle = 35;
  int mismatches = 0;
  int cycles = 0;
  int n_sent = 0;
  int n_hit = 0;
  int n_miss = 0;
  int n_wb = 0;
  int n_range = 0;
  int n_uncached = 0;

  lru_inode_cache_controller #(
    .CACHE_SLOTS(Slots),
    .FILE_COUNT(Files)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic in_t req_of(logic k, int idx);
    in_t r;
    r.kind = k;
    r.record_index = idx[15:0];
    return r;
  endfunction

  function automatic out_t res_of(logic [1:0] st, logic h, int s, logic wb, int wbi);
    out_t r;
    r.status = st;
    r.hit = h;
    r.slot = s[3:0];
    r.writeback_needed = wb;
    r.writeback_index = wbi[9:0];
    return r;
  endfunction

  // Move the chain entry at pos to the most recent end.
  function automatic void promote(int pos, logic [3:0] s);
    for (int i = pos; i > 0; i--) lru_chain[i] = lru_chain[i-1];
    lru_chain[0] = s;
  endfunction

  function automatic out_t dir_update(in_t req);
    out_t res;
    int idx;
    int found;
    int pos;
    logic [3:0] s;
    res = '0;
    idx = $signed(req.record_index);
    found = -1;
    if (idx >= 0) begin
      for (int i = 0; i < slots_filled; i++) begin
        if (rec_tag[i] == idx) found = i;
      end
    end
    if (req.kind == KIND_MARK) begin
      if (found < 0) begin
        res.status = STAT_UNCACHED;
      end else begin
        rec_dirty[found] = 1'b1;
        res.hit = 1'b1;
        res.slot = found[3:0];
      end
      return res;
    end
    if (idx < 0 || idx >= Files) begin
      res.status = STAT_RANGE;
      return res;
    end
    if (found >= 0) begin
      pos = 0;
      for (int i = 0; i < slots_filled; i++) begin
        if (lru_chain[i] == found) pos = i;
      end
      promote(pos, found[3:0]);
      res.hit = 1'b1;
      res.slot = found[3:0];
      return res;
    end
    if (slots_filled < Slots) begin
      s = slots_filled[3:0];
      slots_filled++;
      promote(slots_filled - 1, s);
    end else begin
      // evict the least recent slot, asking for a write-back if it is dirty
      s = lru_chain[Slots-1];
      if (rec_dirty[s]) begin
        res.writeback_needed = 1'b1;
        res.writeback_index = rec_tag[s];
      end
      promote(Slots - 1, s);
    end
    rec_tag[s] = idx[9:0];
    rec_dirty[s] = 1'b0;
    res.slot = s;
    return res;
  endfunction

  function automatic in_t pick_req();
    int r;
    int idx;
    logic k;
    r = $urandom_range(99);
    k = KIND_ACCESS;
    if (r < 62) begin
      idx = hot_set[$urandom_range(hot_set.size() - 1)];
    end else if (r < 80) begin
      k = KIND_MARK;
      idx = hot_set[$urandom_range(hot_set.size() - 1)];
    end else if (r < 88) begin
      idx = $urandom;
    end else if (r < 93) begin
      k = KIND_MARK;
      idx = $urandom;
    end else if (r < 97) begin
      k = ($urandom_range(1) == 0) ? KIND_ACCESS : KIND_MARK;
      case ($urandom_range(5))
        0: idx = 0;
        1: idx = Files - 1;
        2: idx = -1;
        3: idx = Files;
        4: idx = -32768;
        default: idx = 32767;
      endcase
    end else begin
      k = KIND_MARK;
      idx = $urandom_range(Files - 1);
    end
    return req_of(k, idx);
  endfunction

  // Offer one transaction; returns at the edge where it is taken.
  task automatic send_req(in_t req, logic known, out_t want);
    out_t pred;
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = dir_update(req);
    pending_res.push_back(known ? want : pred);
    n_sent++;
  endtask

  // Hold the sender until every outstanding result has drained.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < snk_idle);

  always @(posedge clk) begin
    out_t exp_r;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("cycle %0d: result with nothing outstanding: %p",
                                       cycles, out_data);
      end else begin
        exp_r = pending_res.pop_front();
        if (exp_r.status == STAT_RANGE) n_range++;
        else if (exp_r.status == STAT_UNCACHED) n_uncached++;
        else if (exp_r.hit) n_hit++;
        else n_miss++;
        if (exp_r.writeback_needed) n_wb++;
        if (out_data.status !== exp_r.status || out_data.hit !== exp_r.hit ||
            out_data.slot !== exp_r.slot ||
            out_data.writeback_needed !== exp_r.writeback_needed ||
            out_data.writeback_index !== exp_r.writeback_index) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("cycle %0d: expected status %0d hit %0d slot %0d wb %0d idx %0d", cycles,
                     exp_r.status, exp_r.hit, exp_r.slot, exp_r.writeback_needed,
                     exp_r.writeback_index);
            $display("          got      status %0d hit %0d slot %0d wb %0d idx %0d",
                     out_data.status, out_data.hit, out_data.slot, out_data.writeback_needed,
                     out_data.writeback_index);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RunLimit) begin
      $display("run timed out after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    vec_t plan[$];
    int pool_sizes[5];

    pool_sizes = '{6, 14, 20, 40, 17};
    for (int i = 0; i < Slots; i++) rec_dirty[i] = 1'b0;

    // directed table: expectations typed in where they are obvious
    plan.push_back('{req_of(KIND_MARK, 5), 1'b1, res_of(STAT_UNCACHED, 0, 0, 0, 0)});
    plan.push_back('{req_of(KIND_ACCESS, -1), 1'b1, res_of(STAT_RANGE, 0, 0, 0, 0)});
    plan.push_back('{req_of(KIND_ACCESS, -32768), 1'b1, res_of(STAT_RANGE, 0, 0, 0, 0)});
    plan.push_back('{req_of(KIND_ACCESS, 32767), 1'b1, res_of(STAT_RANGE, 0, 0, 0, 0)});
    plan.push_back('{req_of(KIND_ACCESS, Files), 1'b1, res_of(STAT_RANGE, 0, 0, 0, 0)});
    plan.push_back('{req_of(KIND_ACCESS, 0), 1'b1, res_of(STAT_DONE, 0, 0, 0, 0)});
    plan.push_back('{req_of(KIND_ACCESS, Files - 1), 1'b1, res_of(STAT_DONE, 0, 1, 0, 0)});
    plan.push_back('{req_of(KIND_ACCESS, 0), 1'b1, res_of(STAT_DONE, 1, 0, 0, 0)});
    plan.push_back('{req_of(KIND_MARK, Files - 1), 1'b1, res_of(STAT_DONE, 1, 1, 0, 0)});
    plan.push_back('{req_of(KIND_MARK, -1), 1'b1, res_of(STAT_UNCACHED, 0, 0, 0, 0)});
    plan.push_back('{req_of(KIND_MARK, 32767), 1'b1, res_of(STAT_UNCACHED, 0, 0, 0, 0)});
    // fill the remaining slots, then force a dirty eviction and a re-fetch
    for (int i = 2; i < Slots; i++) plan.push_back('{req_of(KIND_ACCESS, i * 60), 1'b0, '0});
    plan.push_back('{req_of(KIND_ACCESS, 512), 1'b0, '0});
    plan.push_back('{req_of(KIND_ACCESS, Files - 1), 1'b0, '0});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_req(plan[i].req, plan[i].known, plan[i].want);
    settle();

    for (int p = 0; p < 5; p++) begin
      hot_set.delete();
      for (int j = 0; j < pool_sizes[p]; j++) hot_set.push_back($urandom_range(Files - 1));
      src_idle = (p == 1) ? 0 : 35;
      snk_idle = (p == 1) ? 0 : 35;
      for (int j = 0; j < PhaseItems; j++) send_req(pick_req(), 1'b0, '0);
      settle();
    end

    repeat (DrainCycles) @(posedge clk);
    $display("%0d transactions: %0d hits, %0d misses, %0d write-backs, %0d range rejects,",
             n_sent, n_hit, n_miss, n_wb, n_range);
    $display("%0d dirty marks on uncached records, %0d mismatches", n_uncached, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
